FILE: src/orl_pkg.sv
// Shared types, codes and sizes of the ordered record list.
package orl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_REMOVE    = 2'd2,
    REQ_UNKNOWN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_HEAD_WR,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        name;
  } rec_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    rec_t          wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_e       status;
    logic [CW-1:0] list_length;
    logic          valid;
    logic [AW-1:0] pos;
    rec_t          rec;
    logic          last;
  } result_t;

endpackage

FILE: src/ordered_record_list_unit.sv
// Top level of the ordered record list: sequencer, record RAM and output register.
// Insert back writes at the tail; insert front into a filled list moves each record up,
// then writes the head; remove compares records in turn, then moves later ones down, all
// through the single RAM read and write ports. Listing outputs each record; an empty list
// or an unknown request gives a single result. The next item is taken after the
// last result enters the output register. Reset empties the list; RAM is not cleared.
module ordered_record_list_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] rec_key_i,
  input  logic [63:0]        rec_name_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [6:0]         list_length_o,
  output logic               entry_valid_o,
  output logic [5:0]         entry_pos_o,
  output logic signed [31:0] entry_key_o,
  output logic [63:0]        entry_name_o,
  output logic               last_o
);
  import orl_pkg::*;

  ram_req_t ram_req;
  rec_t     ram_rdata;
  result_t  res;
  logic     res_valid;
  logic     res_ready;
  result_t  out_res_q;
  logic     out_valid_q;

  orl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_i       (req_e'(req_type_i)),
    .key_i       (rec_key_i),
    .name_i      (rec_name_i),
    .ram_o       (ram_req),
    .rdata_i     (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  orl_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_res_q.status;
  assign list_length_o = 7'(out_res_q.list_length);
  assign entry_valid_o = out_res_q.valid;
  assign entry_pos_o   = 6'(out_res_q.pos);
  assign entry_key_o   = out_res_q.rec.key;
  assign entry_name_o  = out_res_q.rec.name;
  assign last_o        = out_res_q.last;

endmodule

FILE: src/orl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module orl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/orl_ctrl.sv
// Sequencer that searches, shifts and lists the records through one RAM port pair.
module orl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  orl_pkg::req_e      req_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        name_i,
  output orl_pkg::ram_req_t  ram_o,
  input  orl_pkg::rec_t      rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output orl_pkg::result_t   res_o
);
  import orl_pkg::*;

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  req_e               req_q, req_d;
  logic signed [31:0] key_q, key_d;
  logic [63:0]        name_q, name_d;
  status_e            status_q, status_d;
  logic               idx_at_end;

  assign idx_at_end = (CW'(idx_q) == count_q - CW'(1));
  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      req_q    <= REQ_UNKNOWN;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      req_q    <= req_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    name_q <= name_d;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    req_d    = req_q;
    key_d    = key_q;
    name_d   = name_q;
    status_d = status_q;

    ram_o.we    = 1'b0;
    ram_o.waddr = idx_q;
    ram_o.wdata = rdata_i;
    ram_o.re    = 1'b0;
    ram_o.raddr = idx_q;

    res_valid_o       = 1'b0;
    res_o.status      = status_q;
    res_o.list_length = count_q;
    res_o.valid       = 1'b1;
    res_o.pos         = idx_q;
    res_o.rec         = rdata_i;
    res_o.last        = idx_at_end;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = req_i;
          key_d    = key_i;
          name_d   = name_i;
          status_d = ST_OK;
          idx_d    = '0;
          case (req_i)
            REQ_INS_FRONT, REQ_INS_BACK: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = ST_FULL;
                state_d  = S_LIST_RD;
              end else if (req_i == REQ_INS_BACK || count_q == '0) begin
                ram_o.we    = 1'b1;
                ram_o.waddr = AW'(count_q);
                ram_o.wdata = '{key: key_i, name: name_i};
                count_d     = count_q + CW'(1);
                state_d     = S_LIST_RD;
              end else begin
                idx_d   = AW'(count_q - CW'(1));
                state_d = S_SHIFT_RD;
              end
            end
            REQ_REMOVE: begin
              if (count_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_LIST_OUT;
              end else begin
                state_d = S_SEARCH_RD;
              end
            end
            default: begin
              status_d = ST_INVALID;
              state_d  = S_LIST_OUT;
            end
          endcase
        end
      end

      S_SEARCH_RD: begin
        ram_o.re = 1'b1;
        state_d  = S_SEARCH_CMP;
      end

      S_SEARCH_CMP: begin
        if (rdata_i.key == key_q) begin
          if (idx_at_end) begin
            count_d = count_q - CW'(1);
            idx_d   = '0;
            state_d = (count_d == '0) ? S_LIST_OUT : S_LIST_RD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_SHIFT_RD;
          end
        end else if (idx_at_end) begin
          status_d = ST_NOT_FOUND;
          idx_d    = '0;
          state_d  = S_LIST_RD;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = S_SEARCH_RD;
        end
      end

      S_SHIFT_RD: begin
        ram_o.re = 1'b1;
        state_d  = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        ram_o.we = 1'b1;
        if (req_q == REQ_INS_FRONT) begin
          ram_o.waddr = idx_q + AW'(1);
          if (idx_q == '0) begin
            state_d = S_HEAD_WR;
          end else begin
            idx_d   = idx_q - AW'(1);
            state_d = S_SHIFT_RD;
          end
        end else begin
          ram_o.waddr = idx_q - AW'(1);
          if (idx_at_end) begin
            count_d = count_q - CW'(1);
            idx_d   = '0;
            state_d = S_LIST_RD;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_SHIFT_RD;
          end
        end
      end

      S_HEAD_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = '0;
        ram_o.wdata = '{key: key_q, name: name_q};
        count_d     = count_q + CW'(1);
        idx_d       = '0;
        state_d     = S_LIST_RD;
      end

      S_LIST_RD: begin
        ram_o.re = 1'b1;
        state_d  = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        res_valid_o = 1'b1;
        // An empty list or an unknown request gives one result with no entry.
        if (count_q == '0 || status_q == ST_INVALID) begin
          res_o.valid = 1'b0;
          res_o.pos   = '0;
          res_o.rec   = '0;
          res_o.last  = 1'b1;
        end
        if (res_ready_i) begin
          if (res_o.last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_LIST_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
